// File: rtl/wspc_pkg.sv
`timescale 1ns / 1ps

package wspc_pkg;

    // Window geometry.
    localparam int WINDOW_DEPTH = 16;
    localparam int PTR_W        = 4;
    localparam int CNT_W        = 5;

    // Shared divider geometry and the two iteration counts it runs with.
    localparam int DIV_NUM_W   = 37;
    localparam int DIV_DEN_W   = 32;
    localparam int DIV_ITER_W  = 6;
    localparam logic [DIV_ITER_W-1:0] SLOPE_ITERS = 6'd33;
    localparam logic [DIV_ITER_W-1:0] MEAN_ITERS  = 6'd37;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_TARGET  = 3'd0,
        REG_KP      = 3'd1,
        REG_KI      = 3'd2,
        REG_KD      = 3'd3,
        REG_WINDOW  = 3'd4
    } cfg_reg_t;

    // Input operation codes.
    localparam logic OP_FEED  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_CLR,
        S_PI,
        S_PP,
        S_IH,
        S_IL,
        S_IC,
        S_FETCH0,
        S_BASE,
        S_FETCH,
        S_SLOPE,
        S_DIV,
        S_MEAN,
        S_MDIV,
        S_KDL,
        S_KDH,
        S_KDH2,
        S_FIN
    } state_t;

    // Divider request.
    typedef struct packed {
        logic                  start;
        logic [DIV_ITER_W-1:0] iters;
    } div_req_t;

endpackage

// File: rtl/wspc_div.sv
`timescale 1ns / 1ps

module wspc_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  wspc_pkg::div_req_t            req,
    input  logic [wspc_pkg::DIV_NUM_W-1:0] num,
    input  logic [wspc_pkg::DIV_DEN_W-1:0] den,
    output logic                          done,
    output logic [wspc_pkg::DIV_NUM_W-1:0] quo
);
    import wspc_pkg::*;

    logic                  busy_reg;
    logic [DIV_ITER_W-1:0] cnt_reg;
    logic [DIV_NUM_W-1:0]  num_reg;
    logic [DIV_DEN_W-1:0]  den_reg;
    logic [DIV_DEN_W-1:0]  rem_reg;
    logic [DIV_NUM_W-1:0]  quo_reg;
    logic                  done_reg;

    logic [DIV_DEN_W:0] trial;
    logic [DIV_DEN_W:0] diff;
    logic               ge;

    // One restoring step per cycle, numerator bits from the top.
    assign trial = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.iters;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_ITER_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[DIV_NUM_W-2:0], 1'b0};
            rem_reg <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: rtl/windowed_slope_pid_controller.sv
`timescale 1ns / 1ps

// PID controller with a windowed-slope derivative term.
// Input channel (s_): one beat is one command. s_tuser is the operation
// (feed a sample or clear the running state); s_tdata carries the sample
// and the ticks elapsed since the previous sample.
// Result channel (m_): one beat per command with the new drive in m_tdata
// and the saturation flag in m_tuser.
// Configuration channel (cfg_): register writes, accepted in every cycle;
// write only while the block is idle.
// A feed runs one division for each window entry whose time span against
// the oldest entry is nonzero, skips the division for an entry with a
// zero span, and runs one more division for the mean, all on the shared
// bit-serial divider.
// s_tready is high only while no command is in work. A finished result
// sits in an output register, so the next command can be taken while the
// receiver stalls; a second result then waits until the first is taken.
// Reset clears the window, integral, time and registers (window length 8).
module windowed_slope_pid_controller (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // [15:0] sample_value, [35:16] elapsed_ticks
    input  logic [0:0]  s_tuser,    // [0] operation
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] drive_value
    output logic [0:0]  m_tuser,    // [0] drive_saturated
    // Configuration channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import wspc_pkg::*;

    localparam logic [61:0] MAG_LIMIT = 62'd1 << 60;

    state_t state_reg, state_next;

    // Configuration registers.
    logic signed [15:0] target_reg, kp_reg, kd_reg;
    logic signed [31:0] ki_reg;
    logic [CNT_W-1:0]   wl_reg;

    // Running state.
    logic [CNT_W-1:0]   cnt_reg;
    logic [PTR_W-1:0]   old_reg, pos_reg;
    logic [31:0]        rt_reg;
    logic signed [47:0] integ_reg;

    // Per-item working registers.
    logic signed [15:0] sample_reg, s0_reg;
    logic signed [16:0] err_reg;
    logic [19:0]        ticks_reg;
    logic [31:0]        t0_reg;
    logic [CNT_W-1:0]   k_reg;
    logic [55:0]        hp_reg;
    logic signed [63:0] acc_reg;
    logic signed [37:0] dsum_reg, d_reg;
    logic               qneg_reg, sat_reg;

    // Window memory and its registered read port.
    logic [47:0]        win_mem [WINDOW_DEPTH];
    logic [47:0]        rd_reg;
    logic [PTR_W-1:0]   rd_addr;

    // Shared multiplier.
    logic signed [32:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [57:0] mul_p_reg;

    // Output register.
    logic               m_valid_reg;
    logic [31:0]        m_data_reg;
    logic               m_sat_reg;

    // Divider.
    div_req_t             div_req;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quo;

    logic accept, out_free;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Window bookkeeping for a new sample.
    logic [CNT_W-1:0] len, cnt_keep;
    logic [PTR_W-1:0] old_new;
    always_comb begin
        if (wl_reg == '0) begin
            len = CNT_W'(1);
        end else if (wl_reg > CNT_W'(WINDOW_DEPTH)) begin
            len = CNT_W'(WINDOW_DEPTH);
        end else begin
            len = wl_reg;
        end
        if (cnt_reg >= len) begin
            old_new  = old_reg + PTR_W'(cnt_reg - len + 1'b1);
            cnt_keep = len - 1'b1;
        end else begin
            old_new  = old_reg;
            cnt_keep = cnt_reg;
        end
    end

    // Slope operands from the entry just read.
    logic signed [16:0] sdiff;
    logic [31:0]        span;
    logic [32:0]        snum_mag;
    logic signed [32:0] snum;
    assign sdiff    = 17'(signed'(rd_reg[15:0])) - 17'(s0_reg);
    assign span     = rd_reg[47:16] - t0_reg;
    assign snum     = {sdiff, 16'h0000};
    assign snum_mag = snum[32] ? 33'(-snum) : snum;

    logic [36:0] dsum_mag;
    assign dsum_mag = dsum_reg[37] ? 37'(-dsum_reg) : dsum_reg[36:0];

    // Quotient with its sign restored.
    logic signed [37:0] quo_signed;
    assign quo_signed = qneg_reg ? -38'(div_quo) : 38'(div_quo);

    // Integral accumulate with saturation.
    logic signed [48:0] integ_sum;
    assign integ_sum = 49'(integ_reg) + mul_p_reg[48:0];

    // Integral term magnitude from the two partial products.
    logic [31:0] ki_mag;
    logic [47:0] integ_mag;
    logic [61:0] isum;
    logic [61:0] imag;
    logic        ineg;
    assign ki_mag    = ki_reg[31] ? 32'(-ki_reg) : ki_reg;
    assign integ_mag = integ_reg[47] ? 48'(-integ_reg) : integ_reg;
    assign ineg      = ki_reg[31] != integ_reg[47];
    assign isum      = {hp_reg[37:0], 24'h000000} + {6'h00, mul_p_reg[55:0]};
    assign imag      = ((|hp_reg[55:36]) || (isum > MAG_LIMIT)) ? MAG_LIMIT : isum;

    // Final scaling and clipping.
    logic signed [39:0] q;
    logic               q_clip;
    assign q      = acc_reg[63:24];
    assign q_clip = (q[39:31] != '0) && (q[39:31] != '1);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser[0] == OP_CLEAR) ? S_CLR : S_PI;
                end
            end
            S_CLR:    if (out_free) state_next = S_IDLE;
            S_PI:     state_next = S_PP;
            S_PP:     state_next = S_IH;
            S_IH:     state_next = S_IL;
            S_IL:     state_next = S_IC;
            S_IC:     state_next = S_FETCH0;
            S_FETCH0: state_next = S_BASE;
            S_BASE:   state_next = (cnt_reg == CNT_W'(1)) ? S_MEAN : S_FETCH;
            S_FETCH:  state_next = S_SLOPE;
            S_SLOPE: begin
                if (span != '0) begin
                    state_next = S_DIV;
                end else begin
                    state_next = (k_reg + 1'b1 == cnt_reg) ? S_MEAN : S_FETCH;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = (k_reg + 1'b1 == cnt_reg) ? S_MEAN : S_FETCH;
                end
            end
            S_MEAN:   state_next = S_MDIV;
            S_MDIV:   if (div_done) state_next = S_KDL;
            S_KDL:    state_next = S_KDH;
            S_KDH:    state_next = S_KDH2;
            S_KDH2:   state_next = S_FIN;
            S_FIN:    if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Control outputs: multiplier operands, divider request, read address.
    always_comb begin
        mul_a         = '0;
        mul_b         = '0;
        div_req.start = 1'b0;
        div_req.iters = SLOPE_ITERS;
        div_num       = {snum_mag, 4'h0};
        div_den       = span;
        case (state_reg)
            S_PI: begin
                mul_a = 33'(ticks_reg);
                mul_b = 25'(err_reg);
            end
            S_PP: begin
                mul_a = 33'(kp_reg);
                mul_b = 25'(err_reg);
            end
            S_IH: begin
                mul_a = {1'b0, ki_mag};
                mul_b = {1'b0, integ_mag[47:24]};
            end
            S_IL: begin
                mul_a = {1'b0, ki_mag};
                mul_b = {1'b0, integ_mag[23:0]};
            end
            S_SLOPE: begin
                div_req.start = span != '0;
            end
            S_MEAN: begin
                div_req.start = 1'b1;
                div_req.iters = MEAN_ITERS;
                div_num       = dsum_mag;
                div_den       = 32'(cnt_reg);
            end
            S_KDL: begin
                mul_a = 33'(kd_reg);
                mul_b = {1'b0, d_reg[23:0]};
            end
            S_KDH: begin
                mul_a = 33'(kd_reg);
                mul_b = 25'(signed'(d_reg[37:24]));
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    assign rd_addr = old_reg + k_reg[PTR_W-1:0];

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            target_reg  <= '0;
            kp_reg      <= '0;
            ki_reg      <= '0;
            kd_reg      <= '0;
            wl_reg      <= CNT_W'(8);
            cnt_reg     <= '0;
            old_reg     <= '0;
            rt_reg      <= '0;
            integ_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            // Configuration writes.
            if (cfg_valid) begin
                case (cfg_index)
                    REG_TARGET: target_reg <= cfg_data[15:0];
                    REG_KP:     kp_reg     <= cfg_data[15:0];
                    REG_KI:     ki_reg     <= cfg_data;
                    REG_KD:     kd_reg     <= cfg_data[15:0];
                    REG_WINDOW: wl_reg     <= cfg_data[CNT_W-1:0];
                    default:    ;
                endcase
            end

            // Running state updates.
            if (accept) begin
                if (s_tuser[0] == OP_CLEAR) begin
                    cnt_reg   <= '0;
                    old_reg   <= '0;
                    rt_reg    <= '0;
                    integ_reg <= '0;
                end else begin
                    rt_reg  <= rt_reg + 32'(s_tdata[35:16]);
                    old_reg <= old_new;
                    cnt_reg <= cnt_keep + 1'b1;
                end
            end
            if (state_reg == S_PP) begin
                if (integ_sum[48:47] == 2'b01) begin
                    integ_reg <= {1'b0, {47{1'b1}}};
                end else if (integ_sum[48:47] == 2'b10) begin
                    integ_reg <= {1'b1, {47{1'b0}}};
                end else begin
                    integ_reg <= integ_sum[47:0];
                end
            end

            // Output register.
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if ((state_reg == S_CLR || state_reg == S_FIN) && out_free) begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        mul_p_reg <= mul_a * mul_b;
        rd_reg    <= win_mem[rd_addr];

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    sample_reg <= s_tdata[15:0];
                    ticks_reg  <= s_tdata[35:16];
                    err_reg    <= 17'(target_reg) - 17'(signed'(s_tdata[15:0]));
                    pos_reg    <= old_new + PTR_W'(cnt_keep);
                    sat_reg    <= 1'b0;
                end
            end
            S_CLR: begin
                if (out_free) begin
                    m_data_reg <= '0;
                    m_sat_reg  <= 1'b0;
                end
            end
            S_PP: begin
                win_mem[pos_reg] <= {rt_reg, sample_reg};
                if (integ_sum[48] != integ_sum[47]) begin
                    sat_reg <= 1'b1;
                end
            end
            S_IH: begin
                acc_reg <= 64'(mul_p_reg) <<< 16;
            end
            S_IL: begin
                hp_reg <= mul_p_reg[55:0];
            end
            S_IC: begin
                acc_reg <= ineg ? acc_reg - 64'(imag) : acc_reg + 64'(imag);
                k_reg   <= '0;
            end
            S_BASE: begin
                s0_reg   <= rd_reg[15:0];
                t0_reg   <= rd_reg[47:16];
                dsum_reg <= '0;
                k_reg    <= CNT_W'(1);
            end
            S_SLOPE: begin
                qneg_reg <= snum[32];
                if (span == '0) begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    dsum_reg <= dsum_reg + quo_signed;
                    k_reg    <= k_reg + 1'b1;
                end
            end
            S_MEAN: begin
                qneg_reg <= dsum_reg[37];
            end
            S_MDIV: begin
                if (div_done) begin
                    d_reg <= quo_signed;
                end
            end
            S_KDH: begin
                acc_reg <= acc_reg - 64'(mul_p_reg);
            end
            S_KDH2: begin
                acc_reg <= acc_reg - (64'(mul_p_reg) <<< 24);
            end
            S_FIN: begin
                if (out_free) begin
                    if (q_clip) begin
                        m_data_reg <= q[39] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    end else begin
                        m_data_reg <= q[31:0];
                    end
                    m_sat_reg <= sat_reg || q_clip;
                end
            end
            default: begin
                hp_reg <= hp_reg;
            end
        endcase
    end

    // Shared serial divider.
    wspc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign s_tready  = state_reg == S_IDLE;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_sat_reg;
    assign cfg_ready = 1'b1;

endmodule

// File: verif/windowed_slope_pid_controller_tb.sv
`timescale 1ns / 1ps

module windowed_slope_pid_controller_tb;
    import wspc_pkg::*;

    localparam int WD_LIMIT  = 20000;
    localparam int HOLD_LEN  = 3000;
    localparam int RAND_ITEMS = 130;
    localparam int WINDUP_ITEMS = 40;
    localparam int EXP_DEPTH = 16;
    localparam int ROW_DEPTH = 64;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    windowed_slope_pid_controller dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // One expected result beat.
    typedef struct {
        logic signed [31:0] drive;
        logic               sat;
    } drive_exp_t;

    // Expected beats in order, with running write and read counts.
    drive_exp_t exp_mem[EXP_DEPTH];
    int exp_wr = 0;
    int exp_rd = 0;

    // Directed stimulus rows: an item, or a register write.
    typedef struct {
        bit                 is_cfg;
        logic               op;
        logic signed [15:0] smp;
        logic [19:0]        tk;
        cfg_reg_t           idx;
        logic [31:0]        val;
        bit                 known;
        logic signed [31:0] drive;
        logic               sat;
    } stim_row_t;

    stim_row_t stim_rows[ROW_DEPTH];
    int n_rows;

    // Predictor copy of the registers and the running state.
    logic signed [15:0] p_target, p_kp, p_kd;
    logic signed [31:0] p_ki;
    logic [4:0]         p_win;
    logic signed [15:0] ring_smp[WINDOW_DEPTH];
    logic [31:0]        ring_time[WINDOW_DEPTH];
    int unsigned        ring_cnt, ring_head;
    logic [31:0]        clock_sum;
    longint             integ;

    int errors, n_items, n_results, n_sat, n_clear;
    bit quiet;
    int hold_req_n, hold_done_n, hold_cnt, wd_cnt;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Next drive and saturation flag for one command; updates the state.
    task automatic predict_drive(input logic op, input logic signed [15:0] smp,
                                 input logic [19:0] tk,
                                 output logic signed [31:0] drv, output logic sat);
        longint err, dsum, dd, tot, q, kiv, iterm;
        longint unsigned a, b, hp, mag;
        bit neg;
        int unsigned len, pos, p, k;
        logic [31:0] span;
        sat = 1'b0;
        drv = '0;
        if (op == OP_CLEAR) begin
            ring_cnt = 0;
            ring_head = 0;
            clock_sum = '0;
            integ = 0;
            return;
        end
        err = longint'(p_target) - longint'(smp);
        clock_sum = clock_sum + {12'b0, tk};
        integ = integ + err * longint'({44'b0, tk});
        if (integ > (longint'(1) <<< 47) - 1) begin
            integ = (longint'(1) <<< 47) - 1;
            sat = 1'b1;
        end
        if (integ < -(longint'(1) <<< 47)) begin
            integ = -(longint'(1) <<< 47);
            sat = 1'b1;
        end
        // Window length is clamped to 1..WINDOW_DEPTH.
        len = {27'b0, p_win};
        if (len == 0) len = 1;
        if (len > WINDOW_DEPTH) len = WINDOW_DEPTH;
        while (ring_cnt >= len) begin
            ring_head = (ring_head + 1) % WINDOW_DEPTH;
            ring_cnt--;
        end
        pos = (ring_head + ring_cnt) % WINDOW_DEPTH;
        ring_smp[pos] = smp;
        ring_time[pos] = clock_sum;
        ring_cnt++;
        // Mean slope against the oldest entry; a zero span adds nothing.
        dsum = 0;
        for (k = 1; k < ring_cnt; k++) begin
            p = (ring_head + k) % WINDOW_DEPTH;
            span = ring_time[p] - ring_time[ring_head];
            if (span != 0)
                dsum += ((longint'(ring_smp[p]) - longint'(ring_smp[ring_head])) * 65536)
                        / longint'({32'b0, span});
        end
        dd = dsum / longint'(ring_cnt);
        // Integral product, magnitude clamped to 2^60.
        kiv = longint'(p_ki);
        a = (kiv < 0) ? longint'(-kiv) : kiv;
        b = (integ < 0) ? longint'(-integ) : integ;
        neg = (kiv < 0) != (integ < 0);
        hp = a * (b >> 24);
        if (hp >= (64'd1 << 36)) begin
            mag = 64'd1 << 60;
        end else begin
            mag = (hp << 24) + a * (b & 64'hFFFFFF);
            if (mag > (64'd1 << 60)) mag = 64'd1 << 60;
        end
        iterm = neg ? -longint'(mag) : longint'(mag);
        tot = longint'(p_kp) * err * 65536 + iterm - longint'(p_kd) * dd;
        q = tot >>> 24;
        if (q > 64'sd2147483647) begin
            q = 64'sd2147483647;
            sat = 1'b1;
        end
        if (q < -64'sd2147483648) begin
            q = -64'sd2147483648;
            sat = 1'b1;
        end
        drv = q[31:0];
    endtask

    // Offer one command beat and record its expected result on acceptance.
    task automatic send_cmd(input logic op, input logic signed [15:0] smp,
                            input logic [19:0] tk, input bit known,
                            input logic signed [31:0] kdrv, input logic ksat);
        drive_exp_t e;
        logic signed [31:0] drv;
        logic sat;
        while (!quiet && $urandom_range(99) < 17) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, tk, smp};
        forever begin
            @(negedge aclk);
            if (s_tready) break;
            @(posedge aclk);
        end
        @(posedge aclk);
        predict_drive(op, smp, tk, drv, sat);
        e.drive = known ? kdrv : drv;
        e.sat   = known ? ksat : sat;
        exp_mem[exp_wr % EXP_DEPTH] = e;
        exp_wr++;
        n_items++;
        if (op == OP_CLEAR) n_clear++;
    endtask

    // Wait until every expected beat is back and the block has settled.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (exp_wr != exp_rd) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        forever begin
            @(negedge aclk);
            if (cfg_ready) break;
            @(posedge aclk);
        end
        @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TARGET: p_target = val[15:0];
            REG_KP:     p_kp     = val[15:0];
            REG_KI:     p_ki     = val;
            REG_KD:     p_kd     = val[15:0];
            REG_WINDOW: p_win    = val[4:0];
            default: ;
        endcase
    endtask

    task automatic row_cmd(input logic op, input logic signed [15:0] smp,
                           input logic [19:0] tk, input bit known);
        stim_row_t r;
        r = '{idx: REG_TARGET, default: '0};
        r.op = op;
        r.smp = smp;
        r.tk = tk;
        r.known = known;
        stim_rows[n_rows] = r;
        n_rows++;
    endtask

    task automatic row_reg(input cfg_reg_t idx, input logic [31:0] val);
        stim_row_t r;
        r = '{idx: REG_TARGET, default: '0};
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.val = val;
        stim_rows[n_rows] = r;
        n_rows++;
    endtask

    function automatic logic [19:0] pick_ticks();
        case ($urandom_range(9))
            0:       return 20'd0;
            1, 2:    return 20'($urandom_range(1, 1000));
            3:       return 20'hFFFFF;
            default: return 20'($urandom);
        endcase
    endfunction

    function automatic logic [4:0] pick_window();
        case ($urandom_range(9))
            0:       return 5'd0;
            1:       return 5'd16;
            2:       return 5'd31;
            3:       return 5'($urandom);
            default: return 5'($urandom_range(1, 4));
        endcase
    endfunction

    // Receiver: random stalls, a long hold-off on request, and the result check.
    always @(posedge aclk) begin
        drive_exp_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_cnt > 0) begin
                m_tready <= 1'b0;
                hold_cnt <= hold_cnt - 1;
            end else if (hold_done_n != hold_req_n) begin
                hold_done_n <= hold_req_n;
                hold_cnt <= HOLD_LEN;
                m_tready <= 1'b0;
            end else begin
                m_tready <= quiet || ($urandom_range(99) >= 17);
            end
            if (m_tvalid && m_tready) begin
                n_results++;
                if (m_tuser[0]) n_sat++;
                if (exp_wr == exp_rd) begin
                    report("result beat with nothing expected", m_tdata, 32'h0);
                end else begin
                    e = exp_mem[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (m_tdata !== e.drive) report("drive_value", m_tdata, e.drive);
                    if (m_tuser[0] !== e.sat)
                        report("drive_saturated", {31'b0, m_tuser[0]}, {31'b0, e.sat});
                end
            end
        end
    end

    // Watchdog on cycles without any beat.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            wd_cnt <= 0;
        end else begin
            wd_cnt <= wd_cnt + 1;
            if (wd_cnt == WD_LIMIT) begin
                $display("Timeout: no beat for %0d cycles", WD_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        stim_row_t r;
        logic signed [31:0] kp_sel;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0; n_items = 0; n_results = 0; n_sat = 0; n_clear = 0;
        n_rows = 0;
        quiet = 1'b0;
        hold_req_n = 0; hold_done_n = 0; hold_cnt = 0; wd_cnt = 0;
        p_target = '0; p_kp = '0; p_ki = '0; p_kd = '0; p_win = 5'd8;
        ring_cnt = 0; ring_head = 0; clock_sum = '0; integ = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. With reset gains the drive is zero.
        row_cmd(OP_FEED, 16'sd0, 20'd100, 1'b1);
        row_cmd(OP_FEED, 16'sh7FFF, 20'hFFFFF, 1'b1);
        row_cmd(OP_FEED, 16'sh8000, 20'd0, 1'b1);
        row_cmd(OP_CLEAR, 16'sh1234, 20'h5, 1'b1);
        row_reg(REG_TARGET, 32'd1000);
        row_reg(REG_KP, 32'h0100);
        row_reg(REG_KI, 32'h0001_0000);
        row_reg(REG_KD, 32'h0100);
        row_reg(REG_WINDOW, 32'd4);
        row_cmd(OP_FEED, 16'sd900, 20'd10, 1'b0);
        row_cmd(OP_FEED, 16'sd950, 20'd0, 1'b0);    // zero tick span
        row_cmd(OP_FEED, 16'sd1010, 20'd20, 1'b0);
        row_cmd(OP_FEED, 16'sd1200, 20'd5, 1'b0);
        row_cmd(OP_FEED, -16'sd300, 20'd7, 1'b0);
        row_reg(REG_WINDOW, 32'd2);                  // shrink while full
        row_cmd(OP_FEED, 16'sd400, 20'd3, 1'b0);
        row_reg(REG_WINDOW, 32'd0);                  // zero length acts as one
        row_cmd(OP_FEED, 16'sd401, 20'd3, 1'b0);
        row_reg(REG_WINDOW, 32'd31);                 // above depth acts as full depth
        row_cmd(OP_FEED, 16'sd700, 20'd1, 1'b0);
        row_cmd(OP_FEED, -16'sd700, 20'd2, 1'b0);
        row_reg(REG_TARGET, 32'h7FFF);
        row_reg(REG_KP, 32'h7FFF);
        row_reg(REG_KI, 32'h7FFF_FFFF);
        row_reg(REG_KD, 32'h8000);
        row_cmd(OP_FEED, 16'sh8000, 20'hFFFFF, 1'b0);
        row_cmd(OP_FEED, 16'sh7FFF, 20'd1, 1'b0);
        row_cmd(OP_FEED, 16'sh8000, 20'd0, 1'b0);
        row_reg(REG_TARGET, 32'h8000);
        row_reg(REG_KP, 32'h8000);
        row_reg(REG_KI, 32'h8000_0000);
        row_reg(REG_KD, 32'h7FFF);
        row_cmd(OP_FEED, 16'sh7FFF, 20'hFFFFF, 1'b0);
        row_cmd(OP_FEED, 16'sh8000, 20'd1, 1'b0);
        row_cmd(OP_CLEAR, 16'sd0, 20'd0, 1'b1);
        for (int i = 0; i < n_rows; i++) begin
            r = stim_rows[i];
            if (r.is_cfg) begin
                drain();
                write_reg(r.idx, r.val);
            end else begin
                send_cmd(r.op, r.smp, r.tk, r.known, r.drive, r.sat);
            end
        end

        // Random phases, each with fresh register settings.
        for (int ph = 0; ph < 5; ph++) begin
            drain();
            write_reg(REG_TARGET, $urandom);
            write_reg(REG_KP, $urandom);
            write_reg(REG_KI, $urandom);
            write_reg(REG_KD, $urandom);
            write_reg(REG_WINDOW, 32'(pick_window()));
            quiet = (ph == 2);
            if (ph == 3) hold_req_n++;
            for (int n = 0; n < RAND_ITEMS; n++)
                send_cmd(($urandom_range(99) < 5) ? OP_CLEAR : OP_FEED,
                         16'($urandom), pick_ticks(), 1'b0, '0, 1'b0);
        end
        quiet = 1'b0;

        // Push the integral hard with the largest error and ticks.
        drain();
        write_reg(REG_WINDOW, 32'd1);
        write_reg(REG_TARGET, 32'h7FFF);
        write_reg(REG_KI, 32'h7FFF_FFFF);
        kp_sel = $urandom;
        write_reg(REG_KP, kp_sel);
        write_reg(REG_KD, $urandom);
        for (int n = 0; n < WINDUP_ITEMS; n++)
            send_cmd(OP_FEED, 16'sh8000, 20'hFFFFF, 1'b0, '0, 1'b0);
        for (int n = 0; n < 20; n++)
            send_cmd(OP_FEED, 16'($urandom), pick_ticks(), 1'b0, '0, 1'b0);

        drain();
        repeat (50) @(posedge aclk);
        $display("Covered %0d commands (%0d clears), %0d results, %0d saturated.",
                 n_items, n_clear, n_results, n_sat);
        $display("Window lengths 0..31, gain extremes, zero spans and integral clamp exercised.");
        if (errors == 0 && exp_wr == exp_rd) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results outstanding", errors, exp_wr - exp_rd);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
